// ----- hw/rtl/tdpg_pkg.sv -----
// shared widths, constants and types for the trial division prime generator
`timescale 1ns / 1ps
package tdpg_pkg;

    localparam int DATA_W          = 16;
    localparam int COUNT_W         = 13;
    localparam int INDEX_W         = 12;
    localparam int MAX_PRIMES_DEF  = 1024;

    localparam logic [COUNT_W-1:0] PRIME_COUNT_RESET = 13'd16;
    localparam logic [DATA_W-1:0]  CAND_RESET        = 16'd1;
    localparam logic [DATA_W-1:0]  CAND_MAX          = 16'hFFFF;

    typedef struct packed {
        logic valid;
        logic zero;
    } tdpg_mod_res_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TEST = 3'b010,
        ST_DONE = 3'b100
    } tdpg_state_t;

endpackage

// ----- hw/rtl/tdpg_mod_pipe.sv -----
// pipelined remainder unit, one restoring step per stage, one divisor per cycle
`timescale 1ns / 1ps
module tdpg_mod_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         flush,
    input  logic                         in_valid,
    input  logic [tdpg_pkg::DATA_W-1:0]  in_divisor,
    input  logic [tdpg_pkg::DATA_W-1:0]  dividend,
    output tdpg_pkg::tdpg_mod_res_t      res
);

    localparam int W = tdpg_pkg::DATA_W;

    logic         vld_reg [W];
    logic [W-1:0] rem_reg [W];
    logic [W-1:0] div_reg [W];

    logic         vld_in  [W];
    logic [W-1:0] rem_in  [W];
    logic [W-1:0] div_in  [W];
    logic [W:0]   trial   [W];
    logic [W:0]   diff    [W];
    logic [W-1:0] rem_next[W];

    always_comb begin
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                vld_in[k] = in_valid;
                rem_in[k] = '0;
                div_in[k] = in_divisor;
            end else begin
                vld_in[k] = vld_reg[k-1];
                rem_in[k] = rem_reg[k-1];
                div_in[k] = div_reg[k-1];
            end
            trial[k] = {rem_in[k], dividend[W-1-k]};
            diff[k]  = trial[k] - {1'b0, div_in[k]};
            if (trial[k] >= {1'b0, div_in[k]}) begin
                rem_next[k] = diff[k][W-1:0];
            end else begin
                rem_next[k] = trial[k][W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < W; k++) begin
            if (!aresetn || flush) begin
                vld_reg[k] <= 1'b0;
            end else begin
                vld_reg[k] <= vld_in[k];
            end
            rem_reg[k] <= rem_next[k];
            div_reg[k] <= div_in[k];
        end
    end

    assign res.valid = vld_reg[W-1];
    assign res.zero  = (rem_reg[W-1] == '0);

endmodule

// ----- hw/rtl/trial_division_prime_generator.sv -----
// top level: prime table memory, candidate sequencer and result register
// flow: a request is taken in ST_IDLE; in ST_TEST each candidate is tried against the stored
//   primes and a composite moves on to the next candidate; the result register moves to the
//   output register in ST_DONE once the output register is free
// one word at a time: the next request is taken once the word is in the output register
// reset: synchronous active low; count 0, last candidate 1, prime_count 16
// the prime table is not cleared, entries are only read after they are written
`timescale 1ns / 1ps
module trial_division_prime_generator #(
    parameter int MAX_PRIMES = tdpg_pkg::MAX_PRIMES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tdpg_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_restart,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tdpg_pkg::DATA_W-1:0]    m_prime,
    output logic [tdpg_pkg::INDEX_W-1:0]   m_prime_index,
    output logic                           m_is_last,
    output logic                           m_overrun
);

    localparam int DW    = tdpg_pkg::DATA_W;
    localparam int FW    = tdpg_pkg::COUNT_W;
    localparam int IW    = tdpg_pkg::INDEX_W;
    localparam int AW    = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int CW    = $clog2(MAX_PRIMES + 1);
    localparam logic [FW-1:0] MAX_FC = FW'(MAX_PRIMES);
    localparam logic [CW-1:0] MAX_ST = CW'(MAX_PRIMES);

    tdpg_pkg::tdpg_state_t state_reg, state_next;

    logic [FW-1:0] prime_count_reg, prime_count_next;
    logic [FW-1:0] found_count_reg, found_count_next;
    logic [DW-1:0] last_reg, last_next;
    logic [DW-1:0] cand_reg, cand_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0] ret_cnt_reg, ret_cnt_next;

    logic [DW-1:0] res_prime_reg, res_prime_next;
    logic [IW-1:0] res_index_reg, res_index_next;
    logic          res_last_reg, res_last_next;
    logic          res_overrun_reg, res_overrun_next;

    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_prime_reg, m_prime_next;
    logic [IW-1:0] m_index_reg, m_index_next;
    logic          m_last_reg, m_last_next;
    logic          m_overrun_reg, m_overrun_next;

    logic [DW-1:0] table_mem [MAX_PRIMES];
    logic [DW-1:0] rd_data_reg;
    logic          rd_valid_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic [CW-1:0] stored;
    logic          flush;
    logic          composite;
    logic          begin_search;
    logic [DW-1:0] search_from;
    logic [FW-1:0] fc_eff;
    logic [DW-1:0] last_eff;

    tdpg_pkg::tdpg_mod_res_t mod_res;

    tdpg_mod_pipe u_mod (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (flush),
        .in_valid   (rd_valid_reg),
        .in_divisor (rd_data_reg),
        .dividend   (cand_reg),
        .res        (mod_res)
    );

    // prime table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= cand_reg;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb begin
        if (found_count_reg >= MAX_FC) begin
            stored = MAX_ST;
        end else begin
            stored = CW'(found_count_reg);
        end
    end

    assign composite = (state_reg == tdpg_pkg::ST_TEST) && mod_res.valid && mod_res.zero;
    assign rd_en     = (state_reg == tdpg_pkg::ST_TEST) && (issue_cnt_reg < stored) && !composite;
    assign rd_addr   = issue_cnt_reg[AW-1:0];
    assign wr_addr   = found_count_reg[AW-1:0];
    assign fc_eff    = s_restart ? '0 : found_count_reg;
    assign last_eff  = s_restart ? tdpg_pkg::CAND_RESET : last_reg;

    always_comb begin
        state_next       = state_reg;
        prime_count_next = cfg_wr_en ? cfg_wr_data : prime_count_reg;
        found_count_next = found_count_reg;
        last_next        = last_reg;
        cand_next        = cand_reg;
        issue_cnt_next   = rd_en ? issue_cnt_reg + CW'(1) : issue_cnt_reg;
        ret_cnt_next     = ret_cnt_reg;
        res_prime_next   = res_prime_reg;
        res_index_next   = res_index_reg;
        res_last_next    = res_last_reg;
        res_overrun_next = res_overrun_reg;
        m_valid_next     = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_prime_next     = m_prime_reg;
        m_index_next     = m_index_reg;
        m_last_next      = m_last_reg;
        m_overrun_next   = m_overrun_reg;
        wr_en            = 1'b0;
        flush            = 1'b0;
        begin_search     = 1'b0;
        search_from      = last_reg;

        case (state_reg)
            tdpg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    found_count_next = fc_eff;
                    last_next        = last_eff;
                    if (fc_eff >= prime_count_reg) begin
                        res_prime_next   = '0;
                        res_index_next   = '0;
                        res_last_next    = 1'b0;
                        res_overrun_next = 1'b1;
                        state_next       = tdpg_pkg::ST_DONE;
                    end else begin
                        begin_search = 1'b1;
                        search_from  = last_eff;
                    end
                end
            end
            tdpg_pkg::ST_TEST: begin
                if (composite) begin
                    flush        = 1'b1;
                    begin_search = 1'b1;
                    search_from  = cand_reg;
                end else if (mod_res.valid) begin
                    ret_cnt_next = ret_cnt_reg + CW'(1);
                end else if (ret_cnt_reg == stored) begin
                    // no stored prime divides the candidate
                    wr_en            = (found_count_reg < MAX_FC);
                    last_next        = cand_reg;
                    found_count_next = found_count_reg + FW'(1);
                    res_prime_next   = cand_reg;
                    res_index_next   = found_count_reg[IW-1:0];
                    res_last_next    = ({1'b0, found_count_reg} + (FW+1)'(1))
                                       == {1'b0, prime_count_reg};
                    res_overrun_next = 1'b0;
                    state_next       = tdpg_pkg::ST_DONE;
                end
            end
            tdpg_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_prime_next   = res_prime_reg;
                    m_index_next   = res_index_reg;
                    m_last_next    = res_last_reg;
                    m_overrun_next = res_overrun_reg;
                    state_next     = tdpg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpg_pkg::ST_IDLE;
            end
        endcase

        if (begin_search) begin
            if (search_from == tdpg_pkg::CAND_MAX) begin
                // candidate space exhausted
                last_next        = tdpg_pkg::CAND_MAX;
                res_prime_next   = '0;
                res_index_next   = '0;
                res_last_next    = 1'b0;
                res_overrun_next = 1'b1;
                state_next       = tdpg_pkg::ST_DONE;
            end else begin
                cand_next      = search_from + DW'(1);
                issue_cnt_next = '0;
                ret_cnt_next   = '0;
                state_next     = tdpg_pkg::ST_TEST;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tdpg_pkg::ST_IDLE;
            prime_count_reg <= tdpg_pkg::PRIME_COUNT_RESET;
            found_count_reg <= '0;
            last_reg        <= tdpg_pkg::CAND_RESET;
            issue_cnt_reg   <= '0;
            ret_cnt_reg     <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            prime_count_reg <= prime_count_next;
            found_count_reg <= found_count_next;
            last_reg        <= last_next;
            issue_cnt_reg   <= issue_cnt_next;
            ret_cnt_reg     <= ret_cnt_next;
            rd_valid_reg    <= rd_en;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg        <= cand_next;
        res_prime_reg   <= res_prime_next;
        res_index_reg   <= res_index_next;
        res_last_reg    <= res_last_next;
        res_overrun_reg <= res_overrun_next;
        m_prime_reg     <= m_prime_next;
        m_index_reg     <= m_index_next;
        m_last_reg      <= m_last_next;
        m_overrun_reg   <= m_overrun_next;
    end

    assign s_ready       = (state_reg == tdpg_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_prime       = m_prime_reg;
    assign m_prime_index = m_index_reg;
    assign m_is_last     = m_last_reg;
    assign m_overrun     = m_overrun_reg;

endmodule
